### sv/dix_pkg.sv
// Shared constants for the dictionary index encoder.
// Holds parameter defaults, hash constants and field widths; depends on nothing.
`default_nettype none

package dix_pkg;

   localparam int DefDictCapacity = 1024;
   localparam int DefHashSlots    = 2048;

   localparam int ValueW = 32;
   localparam int PosW   = 31;
   localparam int EpochW = 8;

   localparam logic [ValueW-1:0] HashMult    = 32'h9E3779B1;
   localparam logic [ValueW-1:0] MarkerReset = 32'h80000000;
   localparam logic [PosW-1:0]   PosMax      = {PosW{1'b1}};

endpackage

`default_nettype wire

### sv/dictionary_index_encoder.sv
// Top level of the dictionary index encoder: hash pipeline, probe sequencer and slot memory.
// Depends on dix_pkg for parameter defaults, hash constants and field widths.
`default_nettype none

// Each request carries one signed 32-bit value and is answered by exactly one response.
// The value is hashed in a four-stage unit and looked up with linear probing in a slot
// memory of HASH_SLOTS entries, one slot per cycle. A missing value skips the lookup.
// One request is in flight at a time; the next request is taken while the previous
// response still waits in the output register. Slots are tagged with a chunk epoch, so
// ending a chunk costs nothing, except that after reset and once every 255 chunks the
// memory is swept, during which req_tready stays low. The configuration register is
// written through csr_valid and csr_data and must only be changed while no request is
// in progress.
module dictionary_index_encoder
   #(
      parameter int DICT_CAPACITY = dix_pkg::DefDictCapacity,
      parameter int HASH_SLOTS    = dix_pkg::DefHashSlots,
      localparam int CODE_W  = $clog2(DICT_CAPACITY),
      localparam int COUNT_W = $clog2(DICT_CAPACITY + 1),
      localparam int RSP_BITS = 2 * dix_pkg::ValueW + dix_pkg::PosW + CODE_W + COUNT_W + 4,
      localparam int RSP_W    = ((RSP_BITS + 7) / 8) * 8
   )
   (
      input  wire logic                        clock,
      input  wire logic                        reset,

      input  wire logic                        req_tvalid,
      output      logic                        req_tready,
      // value
      input  wire logic [dix_pkg::ValueW-1:0]  req_tdata,
      input  wire logic                        req_tlast,

      output      logic                        rsp_tvalid,
      input  wire logic                        rsp_tready,
      // code_valid, code, is_new, row_position, entry_count, min_value, max_value,
      // has_min_max, overflow
      output      logic [RSP_W-1:0]            rsp_tdata,

      input  wire logic                        csr_valid,
      output      logic                        csr_ready,
      input  wire logic [dix_pkg::ValueW-1:0]  csr_data
   );

   import dix_pkg::*;

   localparam int SLOT_W = $clog2(HASH_SLOTS);
   localparam int MEM_W  = EpochW + CODE_W + ValueW;
   localparam logic [ValueW-1:0] HashRecip = ValueW'((64'd1 << 32) / HASH_SLOTS);
   localparam logic [ValueW-1:0] SlotCount = ValueW'(HASH_SLOTS);
   localparam logic [SLOT_W-1:0] SlotLast  = SLOT_W'(HASH_SLOTS - 1);
   localparam logic [COUNT_W-1:0] CapCount = COUNT_W'(DICT_CAPACITY);

   localparam logic [2:0] StClear = 3'd0;
   localparam logic [2:0] StIdle  = 3'd1;
   localparam logic [2:0] StHash1 = 3'd2;
   localparam logic [2:0] StHash2 = 3'd3;
   localparam logic [2:0] StHash3 = 3'd4;
   localparam logic [2:0] StProbe = 3'd5;
   localparam logic [2:0] StDone  = 3'd6;

   logic [2:0]          state_ff, state_in;
   logic [SLOT_W-1:0]   clr_cnt_ff, clr_cnt_in;
   logic [EpochW-1:0]   epoch_ff, epoch_in;
   logic [COUNT_W-1:0]  entries_ff, entries_in;
   logic [PosW-1:0]     pos_ff, pos_in;
   logic [ValueW-1:0]   min_ff, min_in;
   logic [ValueW-1:0]   max_ff, max_in;
   logic                seen_ff, seen_in;
   logic [ValueW-1:0]   marker_ff, marker_in;
   logic                rsp_valid_ff, rsp_valid_in;

   logic [ValueW-1:0]   key_ff, key_in;
   logic                last_ff, last_in;
   logic [ValueW-1:0]   hmul_ff, hmul_in;
   logic [ValueW-1:0]   hx_ff, hx_in;
   logic [63:0]         recip_ff, recip_in;
   logic [ValueW-1:0]   qn_ff, qn_in;
   logic [SLOT_W-1:0]   slot_ff, slot_in;
   logic [SLOT_W-1:0]   probes_ff, probes_in;
   logic                res_cv_ff, res_cv_in;
   logic [CODE_W-1:0]   res_code_ff, res_code_in;
   logic                res_new_ff, res_new_in;
   logic                res_ovf_ff, res_ovf_in;
   logic                res_upd_ff, res_upd_in;
   logic [RSP_W-1:0]    rsp_data_ff, rsp_data_in;

   logic [MEM_W-1:0]    slot_mem [HASH_SLOTS];
   logic [MEM_W-1:0]    rd_data_ff;
   logic                wr_en;
   logic [SLOT_W-1:0]   wr_addr;
   logic [MEM_W-1:0]    wr_data;

   logic [ValueW-1:0]   rd_key;
   logic [CODE_W-1:0]   rd_code;
   logic [EpochW-1:0]   rd_epoch;

   assign rd_key   = rd_data_ff[ValueW-1:0];
   assign rd_code  = rd_data_ff[ValueW+CODE_W-1:ValueW];
   assign rd_epoch = rd_data_ff[MEM_W-1:ValueW+CODE_W];

   assign req_tready = (state_ff == StIdle);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_comb begin
      logic [63:0]         mul_full;
      logic [63:0]         qn_full;
      logic [ValueW-1:0]   rem;
      logic [ValueW-1:0]   rem_fix;
      logic                slot_used;
      logic [COUNT_W-1:0]  ent_next;
      logic [ValueW-1:0]   min_next;
      logic [ValueW-1:0]   max_next;
      logic                seen_next;
      logic [EpochW-1:0]   epoch_next;

      state_in     = state_ff;
      clr_cnt_in   = clr_cnt_ff;
      epoch_in     = epoch_ff;
      entries_in   = entries_ff;
      pos_in       = pos_ff;
      min_in       = min_ff;
      max_in       = max_ff;
      seen_in      = seen_ff;
      marker_in    = marker_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;

      key_in      = key_ff;
      last_in     = last_ff;
      hmul_in     = hmul_ff;
      hx_in       = hx_ff;
      recip_in    = recip_ff;
      qn_in       = qn_ff;
      slot_in     = slot_ff;
      probes_in   = probes_ff;
      res_cv_in   = res_cv_ff;
      res_code_in = res_code_ff;
      res_new_in  = res_new_ff;
      res_ovf_in  = res_ovf_ff;
      res_upd_in  = res_upd_ff;
      rsp_data_in = rsp_data_ff;

      wr_en   = 1'b0;
      wr_addr = slot_ff;
      wr_data = '0;

      mul_full   = 64'(req_tdata) * 64'(HashMult);
      qn_full    = 64'(recip_ff[63:32]) * 64'(SlotCount);
      rem        = hx_ff - qn_ff;
      rem_fix    = (rem >= SlotCount) ? (rem - SlotCount) : rem;
      slot_used  = (rd_epoch == epoch_ff);
      ent_next   = entries_ff + COUNT_W'(res_new_ff);
      min_next   = min_ff;
      max_next   = max_ff;
      seen_next  = seen_ff;
      epoch_next = epoch_ff + EpochW'(1);

      if (res_upd_ff) begin
         seen_next = 1'b1;
         if (!seen_ff) begin
            min_next = key_ff;
            max_next = key_ff;
         end else begin
            if ($signed(key_ff) < $signed(min_ff)) begin
               min_next = key_ff;
            end
            if ($signed(max_ff) < $signed(key_ff)) begin
               max_next = key_ff;
            end
         end
      end

      if (csr_valid) begin
         marker_in = csr_data;
      end

      unique case (state_ff)
         StClear: begin
            wr_en      = 1'b1;
            wr_addr    = clr_cnt_ff;
            clr_cnt_in = clr_cnt_ff + SLOT_W'(1);
            if (clr_cnt_ff == SlotLast) begin
               clr_cnt_in = '0;
               state_in   = StIdle;
            end
         end
         StIdle: begin
            if (req_tvalid) begin
               key_in      = req_tdata;
               last_in     = req_tlast;
               hmul_in     = mul_full[ValueW-1:0];
               res_cv_in   = 1'b0;
               res_code_in = '0;
               res_new_in  = 1'b0;
               res_ovf_in  = 1'b0;
               res_upd_in  = 1'b0;
               state_in    = (req_tdata == marker_ff) ? StDone : StHash1;
            end
         end
         StHash1: begin
            hx_in    = hmul_ff ^ (hmul_ff >> 15);
            recip_in = 64'(hx_in) * 64'(HashRecip);
            state_in = StHash2;
         end
         StHash2: begin
            qn_in    = qn_full[ValueW-1:0];
            state_in = StHash3;
         end
         StHash3: begin
            slot_in   = rem_fix[SLOT_W-1:0];
            probes_in = '0;
            state_in  = StProbe;
         end
         StProbe: begin
            if (!slot_used) begin
               res_upd_in = 1'b1;
               state_in   = StDone;
               if (entries_ff < CapCount) begin
                  wr_en       = 1'b1;
                  wr_data     = {epoch_ff, entries_ff[CODE_W-1:0], key_ff};
                  res_cv_in   = 1'b1;
                  res_code_in = entries_ff[CODE_W-1:0];
                  res_new_in  = 1'b1;
               end else begin
                  res_ovf_in = 1'b1;
               end
            end else if (rd_key == key_ff) begin
               res_cv_in   = 1'b1;
               res_code_in = rd_code;
               state_in    = StDone;
            end else if (probes_ff == SlotLast) begin
               res_upd_in = 1'b1;
               res_ovf_in = 1'b1;
               state_in   = StDone;
            end else begin
               probes_in = probes_ff + SLOT_W'(1);
               slot_in   = (slot_ff == SlotLast) ? '0 : slot_ff + SLOT_W'(1);
            end
         end
         StDone: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = RSP_W'({res_ovf_ff, seen_next, max_next, min_next, ent_next,
                                      pos_ff, res_new_ff, res_code_ff, res_cv_ff});
               entries_in   = ent_next;
               min_in       = min_next;
               max_in       = max_next;
               seen_in      = seen_next;
               pos_in       = (pos_ff == PosMax) ? pos_ff : pos_ff + PosW'(1);
               state_in     = StIdle;
               if (last_ff) begin
                  entries_in = '0;
                  min_in     = '0;
                  max_in     = '0;
                  seen_in    = 1'b0;
                  pos_in     = '0;
                  epoch_in   = epoch_next;
                  if (epoch_next == '0) begin
                     epoch_in = EpochW'(1);
                     state_in = StClear;
                  end
               end
            end
         end
         default: begin
            state_in = StIdle;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= slot_mem[slot_in];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= StClear;
         clr_cnt_ff   <= '0;
         epoch_ff     <= EpochW'(1);
         entries_ff   <= '0;
         pos_ff       <= '0;
         min_ff       <= '0;
         max_ff       <= '0;
         seen_ff      <= 1'b0;
         marker_ff    <= MarkerReset;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         epoch_ff     <= epoch_in;
         entries_ff   <= entries_in;
         pos_ff       <= pos_in;
         min_ff       <= min_in;
         max_ff       <= max_in;
         seen_ff      <= seen_in;
         marker_ff    <= marker_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff      <= key_in;
      last_ff     <= last_in;
      hmul_ff     <= hmul_in;
      hx_ff       <= hx_in;
      recip_ff    <= recip_in;
      qn_ff       <= qn_in;
      slot_ff     <= slot_in;
      probes_ff   <= probes_in;
      res_cv_ff   <= res_cv_in;
      res_code_ff <= res_code_in;
      res_new_ff  <= res_new_in;
      res_ovf_ff  <= res_ovf_in;
      res_upd_ff  <= res_upd_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

`default_nettype wire
